[rtl/multi_channel_blink_output_controller_assert.svh]
// Assertion macros shared by the checker of the blink output controller.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef MULTI_CHANNEL_BLINK_OUTPUT_CONTROLLER_ASSERT_SVH
`define MULTI_CHANNEL_BLINK_OUTPUT_CONTROLLER_ASSERT_SVH

// Checked at every edge, reset included.
`define MCBO_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) (prop)) else $error("check failed");

// Checked only while out of reset.
`define MCBO_ASSERT_RUN(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("check failed");

`endif

[rtl/mcbo_pkg.sv]
// Package for the multi-channel blink output controller.
// Holds widths, item kind codes, register indexes and the phase time table.
// No dependencies.
package mcbo_pkg;

    localparam int CHANNELS_DEFAULT = 8;
    localparam int MASK_W           = 8;
    localparam int CHAN_W           = 3;
    localparam int MODE_W           = 8;
    localparam int TIMER_W          = 7;
    localparam int FUNC_W           = 2;
    localparam int CFG_INDEX_W      = 2;
    localparam int S_TDATA_W        = 16;
    localparam int M_TDATA_W        = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SET       = 2'd0,
        FUNC_TICK      = 2'd1,
        FUNC_EMERGENCY = 2'd2,
        FUNC_NONE      = 2'd3
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BLINK_ENABLE    = 2'd0,
        CFG_EMERGENCY_TOGGLE = 2'd1,
        CFG_EMERGENCY_ZERO  = 2'd2
    } cfg_index_t;

    localparam logic [TIMER_W-1:0] TIME_TABLE [4] = '{7'd1, 7'd5, 7'd25, 7'd30};

    // Phase length from a mode byte: the high nibble when the level is high,
    // else the low nibble. Each nibble is a table index and a multiplier less one.
    function automatic logic [TIMER_W-1:0] phase_time(input logic [MODE_W-1:0] mode,
                                                      input logic high);
        logic [1:0]  idx;
        logic [1:0]  mul;
        logic [9:0]  prod;
        idx  = high ? mode[7:6] : mode[3:2];
        mul  = high ? mode[5:4] : mode[1:0];
        prod = 10'(TIME_TABLE[idx]) * (10'(mul) + 10'd1);
        return prod[TIMER_W-1:0];
    endfunction

endpackage

[rtl/multi_channel_blink_output_controller.sv]
// An accepted item's result is registered and shows on m_tdata in the next cycle.
// One item per cycle while the input is not stalled; all channels update in parallel between
// the channel state registers and the result register.
// Input stalls only while a result waits and m_tready is low.
// Reset (synchronous, aresetn low): levels, modes, timers and masks cleared,
// no result pending.
module multi_channel_blink_output_controller #(
    parameter int CHANNELS = mcbo_pkg::CHANNELS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [mcbo_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mcbo_pkg::MASK_W-1:0]       cfg_wdata,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mcbo_pkg::S_TDATA_W-1:0]    s_tdata,  // channel[2:0], mode_byte[10:3]
    input  logic [mcbo_pkg::FUNC_W-1:0]       s_tuser,  // func[1:0]
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mcbo_pkg::M_TDATA_W-1:0]    m_tdata   // output_levels[7:0]
);

    localparam int EXT_W = CHANNELS + mcbo_pkg::MASK_W;

    logic [mcbo_pkg::MASK_W-1:0]    blink_en_reg;
    logic [mcbo_pkg::MASK_W-1:0]    toggle_mask_reg;
    logic [mcbo_pkg::MASK_W-1:0]    zero_mask_reg;

    logic [CHANNELS-1:0]            level_reg;
    logic [CHANNELS-1:0]            level_next;
    logic [mcbo_pkg::MODE_W-1:0]    mode_reg   [CHANNELS];
    logic [mcbo_pkg::MODE_W-1:0]    mode_next  [CHANNELS];
    logic [mcbo_pkg::TIMER_W-1:0]   timer_reg  [CHANNELS];
    logic [mcbo_pkg::TIMER_W-1:0]   timer_next [CHANNELS];

    logic                           m_tvalid_reg;
    logic [mcbo_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [EXT_W-1:0]               blink_ext;
    logic [EXT_W-1:0]               toggle_ext;
    logic [EXT_W-1:0]               zero_ext;
    logic [EXT_W-1:0]               level_ext;
    logic                           emergency_any;
    logic                           accept;
    mcbo_pkg::func_t                func;
    logic [mcbo_pkg::CHAN_W-1:0]    in_channel;
    logic [mcbo_pkg::MODE_W-1:0]    in_mode;

    assign func       = mcbo_pkg::func_t'(s_tuser);
    assign in_channel = s_tdata[mcbo_pkg::CHAN_W-1:0];
    assign in_mode    = s_tdata[mcbo_pkg::CHAN_W+mcbo_pkg::MODE_W-1:mcbo_pkg::CHAN_W];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Masks only reach channels 0 to 7; higher channels see zero bits.
    assign blink_ext  = EXT_W'(blink_en_reg);
    assign toggle_ext = EXT_W'(toggle_mask_reg);
    assign zero_ext   = EXT_W'(zero_mask_reg);

    assign emergency_any = |(toggle_ext & EXT_W'(level_reg));

    always_comb begin
        logic [mcbo_pkg::TIMER_W-1:0] load;
        load = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            level_next[c] = level_reg[c];
            mode_next[c]  = mode_reg[c];
            timer_next[c] = timer_reg[c];
            unique case (func)
                mcbo_pkg::FUNC_SET: begin
                    if (int'(in_channel) == c) begin
                        mode_next[c]  = in_mode;
                        timer_next[c] = '0;
                        level_next[c] = (in_mode != '0);
                    end
                end
                mcbo_pkg::FUNC_TICK: begin
                    if (blink_ext[c]) begin
                        load = mcbo_pkg::phase_time(mode_reg[c], level_reg[c]);
                        if (mode_reg[c] == '0) begin
                            level_next[c] = 1'b0;
                        end else if (timer_reg[c] != '0) begin
                            timer_next[c] = timer_reg[c] - mcbo_pkg::TIMER_W'(1);
                        end else if (load == mcbo_pkg::TIMER_W'(1)) begin
                            // A one-tick phase holds the level; the timer is reloaded with one instead of toggling.
                            timer_next[c] = load;
                        end else begin
                            timer_next[c] = load - mcbo_pkg::TIMER_W'(1);
                            level_next[c] = !level_reg[c];
                        end
                    end
                end
                mcbo_pkg::FUNC_EMERGENCY: begin
                    if (toggle_ext[c]) begin
                        level_next[c] = !emergency_any;
                    end else if (zero_ext[c]) begin
                        level_next[c] = 1'b0;
                    end
                end
                mcbo_pkg::FUNC_NONE: begin
                end
            endcase
        end
    end

    assign level_ext = EXT_W'(level_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_en_reg    <= '0;
            toggle_mask_reg <= '0;
            zero_mask_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mcbo_pkg::CFG_BLINK_ENABLE:     blink_en_reg    <= cfg_wdata;
                mcbo_pkg::CFG_EMERGENCY_TOGGLE: toggle_mask_reg <= cfg_wdata;
                mcbo_pkg::CFG_EMERGENCY_ZERO:   zero_mask_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                mode_reg[c]  <= '0;
                timer_reg[c] <= '0;
            end
        end else if (accept) begin
            level_reg    <= level_next;
            m_tvalid_reg <= 1'b1;
            for (int c = 0; c < CHANNELS; c++) begin
                mode_reg[c]  <= mode_next[c];
                timer_reg[c] <= timer_next[c];
            end
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= level_ext[mcbo_pkg::M_TDATA_W-1:0];
        end
    end

endmodule

[rtl/mcbo_checker.sv]
// Port-level checker for the multi-channel blink output controller.
// Uses mcbo_pkg and the assertion macros header; bound to the top level below.
`include "multi_channel_blink_output_controller_assert.svh"

module mcbo_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mcbo_pkg::M_TDATA_W-1:0]    m_tdata
);

    // Reset leaves no result pending.
    `MCBO_ASSERT_ALWAYS(a_reset_clears_valid, !aresetn |=> !m_tvalid)

    // Every accepted item yields a result in the following cycle.
    `MCBO_ASSERT_RUN(a_item_gives_result, s_tvalid && s_tready |=> m_tvalid)

    // With the output register empty the input side never stalls.
    `MCBO_ASSERT_RUN(a_ready_when_empty, !m_tvalid |-> s_tready)

    // A stalled result holds its value.
    `MCBO_ASSERT_RUN(a_result_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

endmodule

bind multi_channel_blink_output_controller mcbo_checker u_mcbo_checker (.*);
